### src/link_packet_deframer_core_macros.svh
// ---------------------------------------------------------------------------
// Link packet deframer assertion macros
// Concurrent assertion wrappers on clk and rst_n, empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef LINK_PACKET_DEFRAMER_CORE_MACROS_SVH
`define LINK_PACKET_DEFRAMER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define LPD_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("link packet deframer check failed");
`define LPD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("link packet deframer check failed");
`else
`define LPD_ASSERT_SAME(name, ante, cons)
`define LPD_ASSERT_NEXT(name, ante, cons)
`endif

`endif

### src/lpd_pkg.sv
// ---------------------------------------------------------------------------
// Link packet deframer package
// Shared types, codes and constants of the deframer.
// ---------------------------------------------------------------------------
package lpd_pkg;

  localparam logic [1:0] MODE_BYTE  = 2'd0;
  localparam logic [1:0] MODE_SEQ   = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  localparam logic CFG_BUS_TYPE  = 1'b0;
  localparam logic CFG_GPIO_TYPE = 1'b1;

  localparam logic [2:0] BUS_TYPE_RESET  = 3'd0;
  localparam logic [2:0] GPIO_TYPE_RESET = 3'd1;

  localparam logic [4:0] HDR_MIN_LEN   = 5'd3;
  localparam logic [4:0] BUS_MIN_LEN   = 5'd6;
  localparam logic [4:0] GPIO_MIN_LEN  = 5'd5;
  localparam logic [4:0] BUS_HDR_BYTES = 5'd3;
  localparam logic [4:0] SUB_HDR_BYTES = 5'd2;
  localparam logic [4:0] IDX_SEQ       = 5'd1;
  localparam logic [4:0] IDX_ACK       = 5'd2;
  localparam logic [4:0] IDX_SUB_A     = 5'd3;
  localparam logic [4:0] IDX_SUB_B     = 5'd4;
  localparam logic [4:0] IDX_PAYLOAD   = 5'd5;

  localparam logic [2:0] FLAG_TABLE_FULL = 3'b100;

  typedef enum logic [1:0] {
    ST_HEADER,
    ST_BODY,
    ST_DROP
  } parse_state_t;

  typedef enum logic [1:0] {
    PK_OTHER,
    PK_BUS,
    PK_GPIO
  } pkt_kind_t;

  typedef enum logic [2:0] {
    REC_PAYLOAD,
    REC_DONE,
    REC_GPIO,
    REC_STATUS,
    REC_SHORT,
    REC_BADLEN,
    REC_GPIOERR,
    REC_TRUNC
  } rec_kind_t;

  typedef struct packed {
    rec_kind_t  kind;
    logic [7:0] data_byte;
    logic       is_read_data;
    logic [7:0] seq_number;
    logic [7:0] ack_number;
    logic [2:0] flags;
    logic [6:0] target_address;
    logic [4:0] read_length;
    logic [4:0] command_length;
    logic       ack_matched;
    logic [3:0] pending_count;
  } rec_t;

  typedef struct packed {
    logic [1:0] cnt;
    rec_t       r0;
    rec_t       r1;
  } rec_pair_t;

  typedef struct packed {
    logic       reg_en;
    logic       clr_en;
    logic       match_en;
    logic [7:0] key;
  } pend_req_t;

  typedef struct packed {
    logic       full;
    logic       hit;
    logic [3:0] count;
  } pend_rsp_t;

endpackage

### src/lpd_ifs.sv
// ---------------------------------------------------------------------------
// Link packet deframer channels
// Valid/ready channels for input transactions and result records.
// ---------------------------------------------------------------------------
interface lpd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] value;
  logic       end_of_buffer;

  modport source (output valid, mode, value, end_of_buffer, input ready);
  modport sink   (input valid, mode, value, end_of_buffer, output ready);
endinterface

interface lpd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] record_kind;
  logic [7:0] data_byte;
  logic       is_read_data;
  logic [7:0] seq_number;
  logic [7:0] ack_number;
  logic [2:0] flags;
  logic [6:0] target_address;
  logic [4:0] read_length;
  logic [4:0] command_length;
  logic       ack_matched;
  logic [3:0] pending_count;

  modport source (output valid, record_kind, data_byte, is_read_data, seq_number,
                  ack_number, flags, target_address, read_length, command_length,
                  ack_matched, pending_count, input ready);
  modport sink   (input valid, record_kind, data_byte, is_read_data, seq_number,
                  ack_number, flags, target_address, read_length, command_length,
                  ack_matched, pending_count, output ready);
endinterface

### src/link_packet_deframer_core.sv
// ---------------------------------------------------------------------------
// Link packet deframer core
// Parses concatenated link packets from received buffers into records and
// tracks pending sequence numbers against received acknowledges.
// ---------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  in_ch   | in  | valid / ready | mode, value, end_of_buffer
//  out_ch  | out | valid / ready | zero to two result records per transaction
//  cfg_*   | in  | cfg_we        | cfg_index, cfg_wdata (packet type codes)
//
//  One input transaction per cycle while each gives at most one record and
//  out_ch takes it; a transaction that gives two records holds the two-slot
//  result buffer until out_ch takes the second one. A record reaches out_ch
//  through the input register and then the result buffer. Synchronous reset, no
//  clearing pass. in_ch.ready drops while the input register holds a
//  transaction that the result buffer cannot take.
// ---------------------------------------------------------------------------
`include "link_packet_deframer_core_macros.svh"

module link_packet_deframer_core
  import lpd_pkg::*;
#(
  parameter int PENDING_DEPTH = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [2:0] cfg_wdata,
  lpd_in_if.sink     in_ch,
  lpd_out_if.source  out_ch
);

  logic       in_vld_r;
  logic [1:0] in_mode_r;
  logic [7:0] in_value_r;
  logic       in_eob_r;
  logic [2:0] bus_type_r;
  logic [2:0] gpio_type_r;
  logic       go;
  logic       load_ok;
  pend_req_t  req;
  pend_rsp_t  rsp;
  rec_pair_t  pair;

  assign go          = in_vld_r && load_ok;
  assign in_ch.ready = !in_vld_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_mode_r  <= in_ch.mode;
      in_value_r <= in_ch.value;
      in_eob_r   <= in_ch.end_of_buffer;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_type_r  <= BUS_TYPE_RESET;
      gpio_type_r <= GPIO_TYPE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BUS_TYPE:  bus_type_r  <= cfg_wdata;
        CFG_GPIO_TYPE: gpio_type_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  lpd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .mode      (in_mode_r),
    .value     (in_value_r),
    .eob       (in_eob_r),
    .bus_type  (bus_type_r),
    .gpio_type (gpio_type_r),
    .req       (req),
    .rsp       (rsp),
    .pair      (pair)
  );

  lpd_pending_table #(
    .PENDING_DEPTH (PENDING_DEPTH)
  ) u_pending (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  lpd_result_buffer u_result (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (go),
    .pair    (pair),
    .load_ok (load_ok),
    .out_ch  (out_ch)
  );

  `LPD_ASSERT_SAME(a_no_overrun, in_vld_r && !go, !in_ch.ready)
  `LPD_ASSERT_NEXT(a_records_shown, go && pair.cnt != 2'd0, out_ch.valid)
  `LPD_ASSERT_SAME(a_match_on_done, out_ch.valid && out_ch.ack_matched, out_ch.record_kind == REC_DONE)

endmodule

### src/lpd_pending_table.sv
// ---------------------------------------------------------------------------
// Pending sequence table
// Sent sequence numbers with valid bits, parallel acknowledge match and a
// running entry count.
// ---------------------------------------------------------------------------
module lpd_pending_table
  import lpd_pkg::*;
#(
  parameter int PENDING_DEPTH = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  pend_req_t req,
  output pend_rsp_t rsp
);

  localparam int CNT_W = $clog2(PENDING_DEPTH + 1);

  logic [7:0]               seq_mem [PENDING_DEPTH];
  logic [PENDING_DEPTH-1:0] valid_r;
  logic [PENDING_DEPTH-1:0] valid_nxt;
  logic [CNT_W-1:0]         cnt_r;
  logic [CNT_W-1:0]         cnt_nxt;
  logic [PENDING_DEPTH-1:0] free_v;
  logic [PENDING_DEPTH-1:0] free_low;
  logic [PENDING_DEPTH-1:0] hit_v;
  logic [PENDING_DEPTH-1:0] hit_low;
  logic [PENDING_DEPTH-1:0] wr_v;
  logic [CNT_W+3:0]         cnt_ext;

  always_comb begin
    for (int i = 0; i < PENDING_DEPTH; i++) begin
      hit_v[i] = valid_r[i] && (seq_mem[i] == req.key);
    end
  end

  assign free_v   = ~valid_r;
  assign free_low = free_v & (~free_v + PENDING_DEPTH'(1));
  assign hit_low  = hit_v & (~hit_v + PENDING_DEPTH'(1));
  assign wr_v     = req.reg_en ? free_low : '0;

  always_comb begin
    valid_nxt = valid_r;
    cnt_nxt   = cnt_r;
    if (req.clr_en) begin
      valid_nxt = '0;
      cnt_nxt   = '0;
    end else if (req.reg_en && (free_v != '0)) begin
      valid_nxt = valid_r | free_low;
      cnt_nxt   = cnt_r + CNT_W'(1);
    end else if (req.match_en && (hit_v != '0)) begin
      valid_nxt = valid_r & ~hit_low;
      cnt_nxt   = cnt_r - CNT_W'(1);
    end
  end

  assign cnt_ext   = {4'b0, cnt_nxt};
  assign rsp.full  = (free_v == '0);
  assign rsp.hit   = (hit_v != '0);
  assign rsp.count = cnt_ext[3:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      cnt_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < PENDING_DEPTH; i++) begin
      if (wr_v[i]) begin
        seq_mem[i] <= req.key;
      end
    end
  end

endmodule

### src/lpd_parser.sv
// ---------------------------------------------------------------------------
// Packet parser
// Per-transaction packet state update and result record build.
// ---------------------------------------------------------------------------
module lpd_parser
  import lpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       go,
  input  logic [1:0] mode,
  input  logic [7:0] value,
  input  logic       eob,
  input  logic [2:0] bus_type,
  input  logic [2:0] gpio_type,
  output pend_req_t  req,
  input  pend_rsp_t  rsp,
  output rec_pair_t  pair
);

  parse_state_t state_r, state_nxt;
  pkt_kind_t    kind_r, kind_nxt;
  logic [4:0]   len_r, len_nxt;
  logic [4:0]   idx_r, idx_nxt;
  logic [7:0]   seq_r, seq_nxt;
  logic [7:0]   ack_r, ack_nxt;
  logic [7:0]   sa_r, sa_nxt;
  logic [7:0]   sb_r, sb_nxt;
  logic [4:0]   cmd_r, cmd_nxt;

  rec_kind_t  k0, k1;
  logic [1:0] n;
  logic [7:0] d0;
  logic       rd0;
  logic       stat;
  logic [7:0] sdata;
  logic [2:0] sflags;
  logic       err;
  logic       last;
  logic [4:0] size;
  logic [5:0] rl_need;
  logic [2:0] pk_flags;
  logic [6:0] pk_tgt;
  logic [4:0] pk_rl;
  rec_t       base;

  assign last    = (({1'b0, idx_r} + 6'd1) == {1'b0, len_r});
  assign size    = len_r - BUS_HDR_BYTES;
  assign rl_need = {1'b0, value[4:0]} + {1'b0, SUB_HDR_BYTES};

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    len_nxt   = len_r;
    idx_nxt   = idx_r;
    seq_nxt   = seq_r;
    ack_nxt   = ack_r;
    sa_nxt    = sa_r;
    sb_nxt    = sb_r;
    cmd_nxt   = cmd_r;
    req       = '0;
    req.key   = ack_r;
    n         = 2'd0;
    k0        = REC_PAYLOAD;
    k1        = REC_PAYLOAD;
    d0        = '0;
    rd0       = 1'b0;
    stat      = 1'b0;
    sdata     = '0;
    sflags    = '0;
    err       = 1'b0;
    if (go) begin
      case (mode)
        MODE_SEQ: begin
          req.reg_en = 1'b1;
          req.key    = value;
          stat       = 1'b1;
          sdata      = value;
          sflags     = rsp.full ? FLAG_TABLE_FULL : 3'b000;
          n          = 2'd1;
        end
        MODE_CLEAR: begin
          req.clr_en = 1'b1;
          stat       = 1'b1;
          n          = 2'd1;
        end
        MODE_BYTE: begin
          if (state_r == ST_DROP) begin
            if (eob) begin
              state_nxt = ST_HEADER;
            end
          end else begin
            if (state_r == ST_HEADER) begin
              seq_nxt = '0;
              ack_nxt = '0;
              sa_nxt  = '0;
              sb_nxt  = '0;
              cmd_nxt = '0;
              len_nxt = value[4:0];
              idx_nxt = IDX_SEQ;
              if (value[7:5] == bus_type) begin
                kind_nxt = PK_BUS;
              end else if (value[7:5] == gpio_type) begin
                kind_nxt = PK_GPIO;
              end else begin
                kind_nxt = PK_OTHER;
              end
              if (value[4:0] < HDR_MIN_LEN) begin
                k0  = REC_SHORT;
                n   = 2'd1;
                err = 1'b1;
              end else begin
                state_nxt = ST_BODY;
              end
            end else begin
              if (idx_r == IDX_SEQ) begin
                seq_nxt = value;
              end else if (idx_r == IDX_ACK) begin
                ack_nxt = value;
              end else if (kind_r == PK_BUS && len_r >= BUS_MIN_LEN) begin
                if (idx_r == IDX_SUB_A) begin
                  sa_nxt = value;
                end else if (idx_r == IDX_SUB_B) begin
                  sb_nxt = value;
                  if (sa_r[7]) begin
                    if (rl_need > {1'b0, size}) begin
                      k0  = REC_BADLEN;
                      n   = 2'd1;
                      err = 1'b1;
                    end else begin
                      cmd_nxt = size - SUB_HDR_BYTES - (value[7] ? 5'd0 : value[4:0]);
                    end
                  end else begin
                    cmd_nxt = size - SUB_HDR_BYTES;
                  end
                end else begin
                  k0  = REC_PAYLOAD;
                  d0  = value;
                  rd0 = ((idx_r - IDX_PAYLOAD) >= cmd_r);
                  n   = 2'd1;
                  if (last) begin
                    req.match_en = 1'b1;
                    k1           = REC_DONE;
                    n            = 2'd2;
                  end
                end
              end else if (kind_r == PK_GPIO && len_r >= GPIO_MIN_LEN) begin
                if (idx_r == IDX_SUB_A) begin
                  sa_nxt = value;
                  if (value[6]) begin
                    k0  = REC_GPIOERR;
                    n   = 2'd1;
                    err = 1'b1;
                  end
                end else if (idx_r == IDX_SUB_B) begin
                  sb_nxt = value;
                  k0     = REC_GPIO;
                  d0     = value;
                  n      = 2'd1;
                end
              end
              if (!err && last && idx_r >= IDX_ACK
                  && ((kind_r == PK_BUS && len_r < BUS_MIN_LEN)
                      || (kind_r == PK_GPIO && len_r < GPIO_MIN_LEN))) begin
                k0  = REC_SHORT;
                n   = 2'd1;
                err = 1'b1;
              end
              idx_nxt = idx_r + 5'd1;
              if (last) begin
                state_nxt = ST_HEADER;
              end
            end
            if (err) begin
              state_nxt = eob ? ST_HEADER : ST_DROP;
            end else if (eob && state_nxt != ST_HEADER) begin
              state_nxt = ST_HEADER;
              if (n == 2'd0) begin
                k0 = REC_TRUNC;
                n  = 2'd1;
              end else begin
                k1 = REC_TRUNC;
                n  = 2'd2;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    pk_flags = '0;
    pk_tgt   = '0;
    pk_rl    = '0;
    case (kind_nxt)
      PK_BUS: begin
        pk_flags = {sb_nxt[6], sb_nxt[7], sa_nxt[7]};
        pk_tgt   = sa_nxt[6:0];
        pk_rl    = sa_nxt[7] ? sb_nxt[4:0] : 5'd0;
      end
      PK_GPIO: begin
        pk_flags = {sa_nxt[6], sa_nxt[7], 1'b0};
        pk_tgt   = {2'b00, sa_nxt[4:0]};
      end
      default: begin
      end
    endcase

    base                = '0;
    base.seq_number     = seq_nxt;
    base.ack_number     = ack_nxt;
    base.flags          = pk_flags;
    base.target_address = pk_tgt;
    base.read_length    = pk_rl;
    base.command_length = cmd_nxt;
    base.pending_count  = rsp.count;

    pair.cnt = n;
    if (stat) begin
      pair.r0               = '0;
      pair.r0.kind          = REC_STATUS;
      pair.r0.data_byte     = sdata;
      pair.r0.flags         = sflags;
      pair.r0.pending_count = rsp.count;
    end else begin
      pair.r0              = base;
      pair.r0.kind         = k0;
      pair.r0.data_byte    = d0;
      pair.r0.is_read_data = rd0;
    end
    pair.r1             = base;
    pair.r1.kind        = k1;
    pair.r1.ack_matched = (k1 == REC_DONE) && rsp.hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HEADER;
      kind_r  <= PK_OTHER;
      len_r   <= '0;
      idx_r   <= '0;
      seq_r   <= '0;
      ack_r   <= '0;
      sa_r    <= '0;
      sb_r    <= '0;
      cmd_r   <= '0;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
      len_r   <= len_nxt;
      idx_r   <= idx_nxt;
      seq_r   <= seq_nxt;
      ack_r   <= ack_nxt;
      sa_r    <= sa_nxt;
      sb_r    <= sb_nxt;
      cmd_r   <= cmd_nxt;
    end
  end

endmodule

### src/lpd_result_buffer.sv
// ---------------------------------------------------------------------------
// Result buffer
// Two-slot result register; loads the records of one transaction and
// presents them one at a time.
// ---------------------------------------------------------------------------
module lpd_result_buffer
  import lpd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  rec_pair_t        pair,
  output logic             load_ok,
  lpd_out_if.source        out_ch
);

  logic [1:0] cnt_r;
  rec_t       s0_r;
  rec_t       s1_r;
  logic       pop;

  assign pop     = out_ch.valid && out_ch.ready;
  assign load_ok = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= pair.cnt;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s0_r <= pair.r0;
      s1_r <= pair.r1;
    end else if (pop) begin
      s0_r <= s1_r;
    end
  end

  assign out_ch.valid          = (cnt_r != 2'd0);
  assign out_ch.record_kind    = s0_r.kind;
  assign out_ch.data_byte      = s0_r.data_byte;
  assign out_ch.is_read_data   = s0_r.is_read_data;
  assign out_ch.seq_number     = s0_r.seq_number;
  assign out_ch.ack_number     = s0_r.ack_number;
  assign out_ch.flags          = s0_r.flags;
  assign out_ch.target_address = s0_r.target_address;
  assign out_ch.read_length    = s0_r.read_length;
  assign out_ch.command_length = s0_r.command_length;
  assign out_ch.ack_matched    = s0_r.ack_matched;
  assign out_ch.pending_count  = s0_r.pending_count;

endmodule

### test/tb_link_packet_deframer_core.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Link packet deframer core testbench
// Drives buffers of link packets and pending-table operations, mostly
// well-formed packets with random content plus short, oversized, truncated
// and noisy ones. A predictor of the parser and the pending table supplies
// the record stream that every output transaction is checked against.
// ---------------------------------------------------------------------------
module tb_link_packet_deframer_core;
  import lpd_pkg::*;

  localparam int TABLE_DEPTH = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;

  typedef logic [7:0] octets_t[$];

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_index;
  logic [2:0] cfg_wdata;

  lpd_in_if  in_ch ();
  lpd_out_if out_ch ();

  link_packet_deframer_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // parser and pending table as the block should hold them
  logic [2:0]             bus_type_m;
  logic [2:0]             gpio_type_m;
  bit                     in_body;
  pkt_kind_t              kind_m;
  int                     pkt_len;
  int                     byte_idx;
  logic [7:0]             seq_m;
  logic [7:0]             ack_m;
  logic [7:0]             sub_a_m;
  logic [7:0]             sub_b_m;
  int                     cmd_m;
  bit                     dropping;
  logic [7:0]             pend_seq [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] pend_valid;

  rec_t       expected_recs[$];
  logic [7:0] recent_seqs[$];
  int         mismatch_count = 0;
  int         items_sent = 0;
  int         hold_requests = 0;
  bit         gaps_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic void reset_parser_model();
    bus_type_m  = BUS_TYPE_RESET;
    gpio_type_m = GPIO_TYPE_RESET;
    in_body     = 1'b0;
    kind_m      = PK_OTHER;
    pkt_len     = 0;
    byte_idx    = 0;
    seq_m       = '0;
    ack_m       = '0;
    sub_a_m     = '0;
    sub_b_m     = '0;
    cmd_m       = 0;
    dropping    = 1'b0;
    pend_valid  = '0;
  endfunction

  function automatic rec_t build_record(rec_kind_t kind, logic [7:0] data, logic rd_data,
                                        logic matched, bit status, logic [2:0] sflags);
    rec_t r;
    r              = '0;
    r.kind         = kind;
    r.data_byte    = data;
    r.is_read_data = rd_data;
    r.ack_matched  = matched;
    if (status) begin
      r.flags = sflags;
    end else begin
      r.seq_number     = seq_m;
      r.ack_number     = ack_m;
      r.command_length = 5'(cmd_m);
      if (kind_m == PK_BUS) begin
        r.flags          = {sub_b_m[6], sub_b_m[7], sub_a_m[7]};
        r.target_address = sub_a_m[6:0];
        if (sub_a_m[7]) r.read_length = sub_b_m[4:0];
      end else if (kind_m == PK_GPIO) begin
        r.flags          = {sub_a_m[6], sub_a_m[7], 1'b0};
        r.target_address = {2'b00, sub_a_m[4:0]};
      end
    end
    return r;
  endfunction

  function automatic void predict_records(logic [1:0] op, logic [7:0] v, logic eob);
    rec_t recs[$];
    bit   err;
    bit   last;
    bit   stored;
    bit   matched;
    int   idx;
    int   size;
    int   rlen;
    err = 1'b0;
    if (op == MODE_NONE) return;
    if (op == MODE_SEQ) begin
      stored = 1'b0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (!stored && !pend_valid[i]) begin
          pend_seq[i]   = v;
          pend_valid[i] = 1'b1;
          stored        = 1'b1;
        end
      end
      recs = {recs, build_record(REC_STATUS, v, 1'b0, 1'b0, 1'b1,
                                 stored ? 3'b000 : FLAG_TABLE_FULL)};
    end else if (op == MODE_CLEAR) begin
      pend_valid = '0;
      recs = {recs, build_record(REC_STATUS, 8'h00, 1'b0, 1'b0, 1'b1, 3'b000)};
    end else if (dropping) begin
      if (eob) begin
        dropping = 1'b0;
        in_body  = 1'b0;
      end
      return;
    end else if (!in_body) begin
      seq_m   = '0;
      ack_m   = '0;
      sub_a_m = '0;
      sub_b_m = '0;
      cmd_m   = 0;
      pkt_len = v[4:0];
      if (v[7:5] == bus_type_m) kind_m = PK_BUS;
      else if (v[7:5] == gpio_type_m) kind_m = PK_GPIO;
      else kind_m = PK_OTHER;
      byte_idx = 1;
      if (pkt_len < HDR_MIN_LEN) begin
        recs = {recs, build_record(REC_SHORT, 8'h00, 1'b0, 1'b0, 1'b0, 3'b000)};
        err = 1'b1;
      end else begin
        in_body = 1'b1;
      end
    end else begin
      idx  = byte_idx;
      last = (idx + 1 == pkt_len);
      if (idx == IDX_SEQ) begin
        seq_m = v;
      end else if (idx == IDX_ACK) begin
        ack_m = v;
      end else if (kind_m == PK_BUS && pkt_len >= BUS_MIN_LEN) begin
        size = pkt_len - BUS_HDR_BYTES;
        if (idx == IDX_SUB_A) begin
          sub_a_m = v;
        end else if (idx == IDX_SUB_B) begin
          rlen    = v[4:0];
          sub_b_m = v;
          if (sub_a_m[7]) begin
            if (rlen + 2 > size) begin
              recs = {recs, build_record(REC_BADLEN, 8'h00, 1'b0, 1'b0, 1'b0, 3'b000)};
              err = 1'b1;
            end else begin
              cmd_m = size - 2 - (v[7] ? 0 : rlen);
            end
          end else begin
            cmd_m = size - 2;
          end
        end else begin
          recs = {recs, build_record(REC_PAYLOAD, v, (idx - IDX_PAYLOAD) >= cmd_m,
                                     1'b0, 1'b0, 3'b000)};
          if (last) begin
            matched = 1'b0;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
              if (!matched && pend_valid[i] && pend_seq[i] == ack_m) begin
                pend_valid[i] = 1'b0;
                matched       = 1'b1;
              end
            end
            recs = {recs, build_record(REC_DONE, 8'h00, 1'b0, matched, 1'b0, 3'b000)};
          end
        end
      end else if (kind_m == PK_GPIO && pkt_len >= GPIO_MIN_LEN) begin
        if (idx == IDX_SUB_A) begin
          sub_a_m = v;
          if (v[6]) begin
            recs = {recs, build_record(REC_GPIOERR, 8'h00, 1'b0, 1'b0, 1'b0, 3'b000)};
            err = 1'b1;
          end
        end else if (idx == IDX_SUB_B) begin
          sub_b_m = v;
          recs = {recs, build_record(REC_GPIO, v, 1'b0, 1'b0, 1'b0, 3'b000)};
        end
      end
      if (!err && last && idx >= IDX_ACK
          && ((kind_m == PK_BUS && pkt_len < BUS_MIN_LEN)
              || (kind_m == PK_GPIO && pkt_len < GPIO_MIN_LEN))) begin
        recs = {recs, build_record(REC_SHORT, 8'h00, 1'b0, 1'b0, 1'b0, 3'b000)};
        err = 1'b1;
      end
      byte_idx = (idx + 1) & 31;
      if (last) in_body = 1'b0;
    end
    if (op == MODE_BYTE) begin
      if (err) begin
        in_body  = 1'b0;
        dropping = !eob;
      end else if (eob && in_body) begin
        recs = {recs, build_record(REC_TRUNC, 8'h00, 1'b0, 1'b0, 1'b0, 3'b000)};
        in_body = 1'b0;
      end
    end
    foreach (recs[k]) begin
      recs[k].pending_count = 4'($countones(pend_valid));
      expected_recs = {expected_recs, recs[k]};
    end
  endfunction

  function automatic string record_text(rec_t r);
    return $sformatf({"kind=%0d data=%02h rd=%0b seq=%02h ack=%02h flags=%03b ",
                      "addr=%02h rlen=%0d clen=%0d match=%0b pend=%0d"},
                     r.kind, r.data_byte, r.is_read_data, r.seq_number, r.ack_number,
                     r.flags, r.target_address, r.read_length, r.command_length,
                     r.ack_matched, r.pending_count);
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      predict_records(in_ch.mode, in_ch.value, in_ch.end_of_buffer);
  end

  always @(posedge clk) begin : check_records
    rec_t got;
    rec_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.kind           = rec_kind_t'(out_ch.record_kind);
      got.data_byte      = out_ch.data_byte;
      got.is_read_data   = out_ch.is_read_data;
      got.seq_number     = out_ch.seq_number;
      got.ack_number     = out_ch.ack_number;
      got.flags          = out_ch.flags;
      got.target_address = out_ch.target_address;
      got.read_length    = out_ch.read_length;
      got.command_length = out_ch.command_length;
      got.ack_matched    = out_ch.ack_matched;
      got.pending_count  = out_ch.pending_count;
      if (expected_recs.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected record: %s", record_text(got));
      end else begin
        want = expected_recs.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("record mismatch at %0t", $realtime);
            $display("  expected %s", record_text(want));
            $display("  actual   %s", record_text(got));
          end
        end
      end
    end
  end

  initial begin : receiver
    int hold_left;
    int holds_served;
    hold_left    = 0;
    holds_served = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= !(gaps_on && $urandom_range(99) < 15);
      end
    end
  end

  function automatic logic [7:0] rand_octet();
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] ack_choice();
    if (recent_seqs.size() > 0 && $urandom_range(1))
      return recent_seqs[$urandom_range(recent_seqs.size() - 1)];
    return rand_octet();
  endfunction

  function automatic void append_bus_packet(ref octets_t q);
    int         len;
    int         rlen;
    logic [7:0] sub_b;
    len = ($urandom_range(11) == 0) ? $urandom_range(5, 0) : $urandom_range(31, 6);
    q = {q, {bus_type_m, 5'(len)}};
    if (len < 3) return;
    q = {q, rand_octet()};
    q = {q, ack_choice()};
    if (len < 6) begin
      repeat (len - 3) q = {q, rand_octet()};
      return;
    end
    q = {q, rand_octet()};
    rlen       = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(len - 5);
    sub_b      = rand_octet();
    sub_b[4:0] = 5'(rlen);
    q = {q, sub_b};
    repeat (len - 5) q = {q, rand_octet()};
  endfunction

  function automatic void append_gpio_packet(ref octets_t q);
    int         len;
    logic [7:0] pins;
    len = ($urandom_range(9) == 0) ? $urandom_range(4, 0) : $urandom_range(9, 5);
    q = {q, {gpio_type_m, 5'(len)}};
    if (len < 3) return;
    q = {q, rand_octet()};
    q = {q, rand_octet()};
    if (len < 5) begin
      repeat (len - 3) q = {q, rand_octet()};
      return;
    end
    pins    = rand_octet();
    pins[6] = ($urandom_range(7) == 0);
    q = {q, pins};
    repeat (len - 4) q = {q, rand_octet()};
  endfunction

  function automatic void append_other_packet(ref octets_t q);
    logic [2:0] ptype;
    int         len;
    do ptype = 3'($urandom_range(7));
    while (ptype == bus_type_m || ptype == gpio_type_m);
    len = $urandom_range(31);
    q = {q, {ptype, 5'(len)}};
    if (len >= 3) repeat (len - 1) q = {q, rand_octet()};
  endfunction

  function automatic octets_t random_buffer();
    octets_t q;
    int      pick;
    int      cut;
    repeat ($urandom_range(3, 1)) begin
      pick = $urandom_range(19);
      if (pick < 10) append_bus_packet(q);
      else if (pick < 16) append_gpio_packet(q);
      else if (pick < 18) append_other_packet(q);
      else q = {q, rand_octet()};
    end
    // cut short at a random length, which may end the buffer inside a packet
    if ($urandom_range(7) == 0) begin
      cut = $urandom_range(q.size(), 1);
      repeat (q.size() - cut) void'(q.pop_back());
    end
    return q;
  endfunction

  task automatic send_item(logic [1:0] op, logic [7:0] val, logic eob);
    while (gaps_on && $urandom_range(99) < 15) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.mode          <= op;
    in_ch.value         <= val;
    in_ch.end_of_buffer <= eob;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (op != MODE_NONE) items_sent++;
  endtask

  task automatic send_table_op();
    int         pick;
    logic [7:0] s;
    pick = $urandom_range(9);
    s    = rand_octet();
    if (pick == 0) begin
      send_item(MODE_CLEAR, s, 1'($urandom_range(1)));
    end else if (pick == 1) begin
      send_item(MODE_NONE, s, 1'($urandom_range(1)));
    end else begin
      recent_seqs = {recent_seqs, s};
      if (recent_seqs.size() > TABLE_DEPTH) void'(recent_seqs.pop_front());
      send_item(MODE_SEQ, s, 1'($urandom_range(1)));
    end
  endtask

  task automatic send_buffer(octets_t bytes, bit with_table_ops);
    foreach (bytes[i]) begin
      if (with_table_ops && $urandom_range(24) == 0) send_table_op();
      send_item(MODE_BYTE, bytes[i], i == bytes.size() - 1);
    end
  endtask

  // hold off until every record is back and the pipeline is empty
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_recs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_types(logic [2:0] bus_t, logic [2:0] gpio_t);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BUS_TYPE;
    cfg_wdata <= bus_t;
    @(posedge clk);
    cfg_index <= CFG_GPIO_TYPE;
    cfg_wdata <= gpio_t;
    @(posedge clk);
    cfg_we      <= 1'b0;
    bus_type_m  = bus_t;
    gpio_type_m = gpio_t;
  endtask

  task automatic test_table_ops();
    send_item(MODE_SEQ, 8'h3C, 1'b0);
    send_item(MODE_SEQ, 8'hFF, 1'b1);
    send_item(MODE_NONE, 8'hAA, 1'b1);
  endtask

  task automatic test_bus_transfer();
    send_buffer('{{bus_type_m, 5'd7}, 8'h00, 8'h3C, 8'hFF, 8'h01, 8'h5A, 8'hC3}, 1'b0);
  endtask

  task automatic test_error_cases();
    send_buffer('{{bus_type_m, 5'd2}, 8'hFF}, 1'b0);
    send_buffer('{{bus_type_m, 5'd6}, 8'h11, 8'h22, 8'h85, 8'hDF}, 1'b0);
    send_buffer('{{gpio_type_m, 5'd5}, 8'h33, 8'h44, 8'h5F}, 1'b0);
    send_buffer('{{3'd7, 5'd9}}, 1'b0);
  endtask

  task automatic test_gpio_and_clear();
    send_buffer('{{gpio_type_m, 5'd5}, 8'h80, 8'h7F, 8'h9F, 8'hA5}, 1'b0);
    send_item(MODE_CLEAR, 8'h00, 1'b0);
  endtask

  task automatic test_backpressure();
    octets_t q;
    wait_idle();
    gaps_on = 1'b0;
    hold_requests++;
    repeat (4) begin
      q = {};
      append_bus_packet(q);
      send_buffer(q, 1'b0);
    end
    wait_idle();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_traffic(logic [2:0] bus_t, logic [2:0] gpio_t, int count,
                                     bit with_gaps);
    int stop_at;
    write_types(bus_t, gpio_t);
    gaps_on = with_gaps;
    stop_at = items_sent + count;
    while (items_sent < stop_at) send_buffer(random_buffer(), 1'b1);
    wait_idle();
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_index           <= CFG_BUS_TYPE;
    cfg_wdata           <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.mode          <= MODE_BYTE;
    in_ch.value         <= '0;
    in_ch.end_of_buffer <= 1'b0;
    reset_parser_model();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_table_ops();
    test_bus_transfer();
    test_error_cases();
    test_gpio_and_clear();
    test_backpressure();
    test_random_traffic(3'd7, 3'd0, 325, 1'b1);
    test_random_traffic(3'd3, 3'd3, 325, 1'b0);
    test_random_traffic(3'($urandom_range(7)), 3'($urandom_range(7)), 325, 1'b1);
    test_random_traffic(3'd0, 3'd7, 325, 1'b1);

    wait_idle();
    if (mismatch_count == 0 && expected_recs.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/lpd_pkg.sv
src/lpd_ifs.sv
src/lpd_pending_table.sv
src/lpd_parser.sv
src/lpd_result_buffer.sv
src/link_packet_deframer_core.sv
test/tb_link_packet_deframer_core.sv
